@@ rtl/sfp_pkg.sv @@
// Shared types and constants for the sync-framed UART frame parser.
`timescale 1ns / 1ps
package sfp_pkg;

  localparam logic [7:0]  SYNC_A        = 8'h80;
  localparam logic [7:0]  SYNC_B        = 8'hA5;
  localparam int          MAX_FRAME     = 38;
  localparam int          BANKS         = 4;
  localparam int          IDX_W         = 6;
  localparam int          BANK_W        = 2;
  localparam int          ADDR_W        = BANK_W + IDX_W;
  localparam int          RAM_DEPTH     = 1 << ADDR_W;
  localparam logic [9:0]  TPU_RESET     = 10'd100;
  localparam logic [15:0] DELAY_MAX     = 16'hFFFF;

  // Descriptor of one completed frame, passed from front to back
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  len;
    logic [31:0]       start_tick;
    logic              awaiting;
    logic [31:0]       req_end_tick;
    logic              have_prev;
    logic [31:0]       prev_end_tick;
    logic [31:0]       skip_total;
  } frame_desc_t;

  // Frame length from the control byte: 4 + 2*(bits 4:1 + 1) + 2
  function automatic logic [IDX_W-1:0] frame_len(input logic [7:0] ctrl);
    frame_len = {1'b0, ctrl[4:1], 1'b0} + 6'd8;
  endfunction

endpackage

@@ rtl/sfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sfp_queue.sv @@
// Two-entry queue of frame descriptors between the front and back parts.
`timescale 1ns / 1ps
module sfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfp_pkg::frame_desc_t push_desc,
  input  logic                pop,
  output sfp_pkg::frame_desc_t head,
  output logic                not_empty,
  output logic                full
);

  sfp_pkg::frame_desc_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule

@@ rtl/sfp_front.sv @@
// Front part: sync hunt, header decode, request detection, frame capture.
`timescale 1ns / 1ps
module sfp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  rx_byte,
  input  logic [31:0]                 byte_time,
  output logic                        ram_wr_en,
  output logic [sfp_pkg::ADDR_W-1:0]  ram_wr_addr,
  output logic                        push,
  output sfp_pkg::frame_desc_t        push_desc
);

  logic [sfp_pkg::IDX_W-1:0]  fill;
  logic [sfp_pkg::BANK_W-1:0] bank;
  logic [7:0]  ctrl;
  logic [7:0]  byte4;
  logic [31:0] start_tick;
  logic [31:0] hdr_end_tick;
  logic [31:0] look_tick;
  logic [31:0] req_end_tick;
  logic        awaiting;
  logic [31:0] prev_end_tick;
  logic        have_prev;
  logic [31:0] skip_total;

  logic [sfp_pkg::IDX_W-1:0] fill_inc;
  logic is_request;
  logic done;

  assign fill_inc   = fill + 6'd1;
  assign is_request = (fill == 6'd5) && ctrl[7] && (byte4 == sfp_pkg::SYNC_A) &&
                      (rx_byte == sfp_pkg::SYNC_B);
  assign done       = (fill >= 6'd3) && !is_request &&
                      (fill_inc == sfp_pkg::frame_len(ctrl));

  // sync bytes are known constants, so only bytes from index 2 are stored
  assign ram_wr_en   = accept && (fill >= 6'd2);
  assign ram_wr_addr = {bank, fill};
  assign push        = accept && done;

  always_comb begin
    push_desc               = '0;
    push_desc.bank          = bank;
    push_desc.len           = fill_inc;
    push_desc.start_tick    = start_tick;
    push_desc.awaiting      = awaiting;
    push_desc.req_end_tick  = req_end_tick;
    push_desc.have_prev     = have_prev;
    push_desc.prev_end_tick = prev_end_tick;
    push_desc.skip_total    = skip_total;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      bank          <= '0;
      start_tick    <= '0;
      hdr_end_tick  <= '0;
      look_tick     <= '0;
      req_end_tick  <= '0;
      awaiting      <= 1'b0;
      prev_end_tick <= '0;
      have_prev     <= 1'b0;
      skip_total    <= '0;
    end else if (accept) begin
      case (fill)
        6'd0: begin
          start_tick <= byte_time;
          if (rx_byte != sfp_pkg::SYNC_A) begin
            skip_total <= skip_total + 32'd1;
          end else begin
            fill <= 6'd1;
          end
        end
        6'd1: begin
          if (rx_byte == sfp_pkg::SYNC_B) begin
            fill <= 6'd2;
          end else begin
            // drop the old first byte; a SYNC_A byte becomes the new first, else both go
            start_tick <= byte_time;
            if (rx_byte == sfp_pkg::SYNC_A) begin
              skip_total <= skip_total + 32'd1;
            end else begin
              skip_total <= skip_total + 32'd2;
              fill       <= 6'd0;
            end
          end
        end
        default: begin
          fill <= fill_inc;
          if (fill == 6'd2) begin
            ctrl <= rx_byte;
          end
          if (fill == 6'd3) begin
            hdr_end_tick <= byte_time;
          end
          if (fill == 6'd4) begin
            look_tick <= byte_time;
            byte4     <= rx_byte;
          end
          if (is_request) begin
            // read request consumed; its trailing sync pair starts a frame
            req_end_tick <= hdr_end_tick;
            awaiting     <= 1'b1;
            start_tick   <= look_tick;
            fill         <= 6'd2;
          end else if (done) begin
            awaiting      <= 1'b0;
            prev_end_tick <= byte_time;
            have_prev     <= 1'b1;
            fill          <= '0;
            bank          <= bank + 2'd1;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/sfp_back.sv @@
// Back part: time conversion on a shared serial divider, then the byte run.
`timescale 1ns / 1ps
module sfp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [9:0]                  ticks_per_us,
  input  logic                        q_not_empty,
  input  sfp_pkg::frame_desc_t        q_head,
  output logic                        q_pop,
  output logic [sfp_pkg::ADDR_W-1:0]  ram_rd_addr,
  input  logic [7:0]                  ram_rd_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  frame_byte,
  output logic [5:0]                  byte_index,
  output logic                        last,
  output logic [5:0]                  frame_length,
  output logic [31:0]                 start_time_us,
  output logic [15:0]                 response_delay_us,
  output logic [15:0]                 inter_frame_delay_us,
  output logic [31:0]                 sync_skip_count
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_LD, S_HOLD} state_t;
  typedef enum logic [1:0] {DIV_START, DIV_RESP, DIV_IFD} div_sel_t;

  state_t state;
  sfp_pkg::frame_desc_t desc;
  div_sel_t    div_sel;
  logic [4:0]  step;
  logic [31:0] quo;
  logic [10:0] rem;
  logic [5:0]  k;

  logic [10:0] rem_shift;
  logic        fits;
  logic [10:0] rem_next;
  logic [31:0] quo_next;
  logic [15:0] sat_q;
  logic [31:0] resp_dividend;
  logic [31:0] ifd_dividend;

  // one quotient bit per cycle
  assign rem_shift = {rem[9:0], quo[31]};
  assign fits      = (rem_shift >= {1'b0, ticks_per_us});
  assign rem_next  = fits ? (rem_shift - {1'b0, ticks_per_us}) : rem_shift;
  assign quo_next  = {quo[30:0], fits};
  assign sat_q     = (quo_next[31:16] != 16'd0) ? sfp_pkg::DELAY_MAX : quo_next[15:0];

  assign resp_dividend = desc.start_tick - desc.req_end_tick;
  assign ifd_dividend  = desc.start_tick - desc.prev_end_tick;

  assign q_pop       = (state == S_IDLE) && q_not_empty;
  assign ram_rd_addr = {desc.bank, k};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            desc    <= q_head;
            quo     <= q_head.start_tick;
            rem     <= '0;
            step    <= '0;
            div_sel <= DIV_START;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == 5'd31) begin
            rem  <= '0;
            step <= '0;
            case (div_sel)
              DIV_START: begin
                start_time_us <= (ticks_per_us == 10'd0) ? 32'd0 : quo_next;
                quo           <= resp_dividend;
                div_sel       <= DIV_RESP;
              end
              DIV_RESP: begin
                response_delay_us <= (ticks_per_us == 10'd0 || !desc.awaiting) ?
                                     16'd0 : sat_q;
                quo               <= ifd_dividend;
                div_sel           <= DIV_IFD;
              end
              default: begin
                inter_frame_delay_us <= (ticks_per_us == 10'd0 || !desc.have_prev) ?
                                        16'd0 : sat_q;
                frame_length         <= desc.len;
                sync_skip_count      <= desc.skip_total;
                k                    <= '0;
                state                <= S_RD;
              end
            endcase
          end else begin
            quo  <= quo_next;
            rem  <= rem_next;
            step <= step + 5'd1;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (k == 6'd0) begin
            frame_byte <= sfp_pkg::SYNC_A;
          end else if (k == 6'd1) begin
            frame_byte <= sfp_pkg::SYNC_B;
          end else begin
            frame_byte <= ram_rd_data;
          end
          byte_index <= k;
          last       <= (k + 6'd1 == desc.len);
          out_valid  <= 1'b1;
          state      <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 6'd1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/sync_framed_uart_frame_parser_core.sv @@
// Top level of the sync-framed UART frame parser.
// The parser takes one received byte per cycle on the input channel while
// fewer than two completed frames wait for output. Each completed frame then
// passes through the back part's one-bit-per-cycle divider (start time,
// response delay, inter-frame delay in turn); each byte is then read from
// RAM, loaded and held while out_stall is high. Frame bytes sit in a
// four-bank RAM so capture of new frames overlaps the output of older ones.
`timescale 1ns / 1ps
module sync_framed_uart_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  ticks_per_us,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] byte_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic [5:0]  byte_index,
  output logic        last,
  output logic [5:0]  frame_length,
  output logic [31:0] start_time_us,
  output logic [15:0] response_delay_us,
  output logic [15:0] inter_frame_delay_us,
  output logic [31:0] sync_skip_count
);

  logic [9:0] tpu;
  logic       in_accept;
  logic       q_full;
  logic       q_not_empty;
  logic       q_push;
  logic       q_pop;
  sfp_pkg::frame_desc_t push_desc;
  sfp_pkg::frame_desc_t q_head;
  logic                        ram_wr_en;
  logic [sfp_pkg::ADDR_W-1:0]  ram_wr_addr;
  logic [sfp_pkg::ADDR_W-1:0]  ram_rd_addr;
  logic [7:0]                  ram_rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tpu <= sfp_pkg::TPU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tpu <= ticks_per_us;
    end
  end

  sfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .rx_byte    (rx_byte),
    .byte_time  (byte_time),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .push       (q_push),
    .push_desc  (push_desc)
  );

  sfp_ram #(
    .WIDTH(8),
    .DEPTH(sfp_pkg::RAM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(rx_byte),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  sfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  sfp_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .ticks_per_us        (tpu),
    .q_not_empty         (q_not_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .ram_rd_addr         (ram_rd_addr),
    .ram_rd_data         (ram_rd_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .frame_byte          (frame_byte),
    .byte_index          (byte_index),
    .last                (last),
    .frame_length        (frame_length),
    .start_time_us       (start_time_us),
    .response_delay_us   (response_delay_us),
    .inter_frame_delay_us(inter_frame_delay_us),
    .sync_skip_count     (sync_skip_count)
  );

endmodule
